FILE: rtl/clt_pkg.sv
// command line tokenizer: shared types and constants
// character classes, token kinds, tokenizer state and queue entry layout
// no dependencies
`default_nettype none

package clt_pkg;

    // token kinds as carried on the output tuser
    typedef enum logic [3:0] {
        K_WCHAR = 4'd0,
        K_WEND  = 4'd1,
        K_OPEN  = 4'd2,
        K_CLOSE = 4'd3,
        K_IN    = 4'd4,
        K_INH   = 4'd5,
        K_OUT   = 4'd6,
        K_APP   = 4'd7,
        K_OUTH  = 4'd8,
        K_AMP   = 4'd9,
        K_AMP2  = 4'd10,
        K_PIPE  = 4'd11,
        K_PIPE2 = 4'd12,
        K_END   = 4'd13
    } t_kind;

    // operator characters as found by the classifier
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_AMP     = 3'd1,
        OP_PIPE    = 3'd2,
        OP_LESS    = 3'd3,
        OP_GREATER = 3'd4,
        OP_OPEN    = 3'd5,
        OP_CLOSE   = 3'd6
    } t_op;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEL     = 8'h85;
    localparam logic [7:0] CH_NBSP    = 8'hA0;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [1:0] RUN_MAX    = 2'd2;

    typedef struct packed {
        logic is_quote;
        logic is_caret;
        logic is_ws;
        t_op  op;
    } t_char_class;

    // one queued character with its class
    typedef struct packed {
        logic [7:0]  ch;
        logic        eoi;
        t_char_class cls;
    } t_entry;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_queue_head;

    typedef struct packed {
        logic       split_pending;
        logic       word_open;
        logic [1:0] quote_run;
        logic       quoting;
        logic       escape_pending;
        logic       open_paren_seen;
        logic       close_paren_seen;
        logic [1:0] amp_run;
        logic [1:0] pipe_run;
        logic [1:0] less_run;
        logic [1:0] greater_run;
    } t_tok_state;

endpackage

`default_nettype wire

FILE: rtl/clt_front.sv
// command line tokenizer front end: input transfer, character classing, queue
// depends on clt_pkg
`default_nettype none

module clt_front #(
    parameter int DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_ch,
    input  wire logic                 i_eoi,
    input  wire logic                 i_pop,
    output clt_pkg::t_queue_head      o_head
);
    import clt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    t_char_class        w_cls;
    logic               w_push;
    logic               w_pop;

    // character classifier
    always_comb begin
        w_cls = '{is_quote: 1'b0, is_caret: 1'b0, is_ws: 1'b0, op: OP_NONE};
        unique case (i_ch) inside
            [8'd9:8'd13], CH_SPACE, CH_NEL, CH_NBSP: w_cls.is_ws = 1'b1;
            CH_QUOTE:   w_cls.is_quote = 1'b1;
            CH_CARET:   w_cls.is_caret = 1'b1;
            CH_AMP:     w_cls.op = OP_AMP;
            CH_PIPE:    w_cls.op = OP_PIPE;
            CH_LESS:    w_cls.op = OP_LESS;
            CH_GREATER: w_cls.op = OP_GREATER;
            CH_LPAREN:  w_cls.op = OP_OPEN;
            CH_RPAREN:  w_cls.op = OP_CLOSE;
            default:    w_cls.op = OP_NONE;
        endcase
    end

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_count != '0);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= '{ch: i_ch, eoi: i_eoi, cls: w_cls};
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

FILE: rtl/clt_back.sv
// command line tokenizer back end: tokenizer state, token passes, output register
// depends on clt_pkg
`default_nettype none

module clt_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire clt_pkg::t_queue_head i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [3:0]                o_kind,
    output logic [7:0]                o_word_char,
    output logic                      o_last
);
    import clt_pkg::*;

    typedef struct packed {
        t_tok_state st;
        logic       emit;
        t_kind      kind;
        logic [7:0] wchar;
        logic       done;
    } t_pass;

    function automatic logic [1:0] f_sat_inc(logic [1:0] v);
        return (v >= RUN_MAX) ? RUN_MAX : v + 2'd1;
    endfunction

    // one pass over a character; done marks the character as used up
    function automatic t_pass f_pass(t_tok_state s, t_char_class c, logic [7:0] ch);
        t_pass p;
        p.st    = s;
        p.emit  = 1'b0;
        p.kind  = K_WCHAR;
        p.wchar = '0;
        p.done  = 1'b1;
        if (s.split_pending && s.word_open) begin
            // a pending split ends the open word first
            p.st.split_pending = 1'b0;
            p.st.word_open     = 1'b0;
            p.emit             = 1'b1;
            p.kind             = K_WEND;
            p.done             = 1'b0;
        end else begin
            p.st.split_pending = 1'b0;
            if (c.is_quote) begin
                if (s.quote_run == RUN_MAX) begin
                    // third quote in a row is a literal quote
                    p.st.quote_run = '0;
                    p.st.word_open = 1'b1;
                    p.emit         = 1'b1;
                    p.wchar        = CH_QUOTE;
                end else begin
                    p.st.quote_run = s.quote_run + 2'd1;
                end
            end else if (!s.quoting && !s.escape_pending && c.op != OP_NONE) begin
                p.st.split_pending = 1'b1;
                case (c.op)
                    OP_AMP:     p.st.amp_run = f_sat_inc(s.amp_run);
                    OP_PIPE:    p.st.pipe_run = f_sat_inc(s.pipe_run);
                    OP_LESS:    p.st.less_run = f_sat_inc(s.less_run);
                    OP_GREATER: p.st.greater_run = f_sat_inc(s.greater_run);
                    OP_OPEN:    p.st.open_paren_seen = 1'b1;
                    OP_CLOSE:   p.st.close_paren_seen = 1'b1;
                    default:    p.st.split_pending = 1'b0;
                endcase
            end else begin
                // a lone quote toggles quoting, any quote run is dropped
                if (s.quote_run == 2'd1) begin
                    p.st.quoting = ~s.quoting;
                end
                p.st.quote_run = '0;
                if (s.open_paren_seen) begin
                    p.st.open_paren_seen = 1'b0;
                    p.emit = 1'b1;
                    p.kind = K_OPEN;
                    p.done = 1'b0;
                end else if (s.close_paren_seen) begin
                    p.st.close_paren_seen = 1'b0;
                    p.emit = 1'b1;
                    p.kind = K_CLOSE;
                    p.done = 1'b0;
                end else if (s.less_run != '0) begin
                    p.st.less_run = '0;
                    p.st.amp_run  = '0;
                    p.emit = 1'b1;
                    p.kind = (s.amp_run != '0) ? K_INH : K_IN;
                    p.done = 1'b0;
                end else if (s.greater_run != '0) begin
                    p.st.greater_run = '0;
                    p.st.amp_run     = '0;
                    p.emit = 1'b1;
                    if (s.amp_run != '0) begin
                        p.kind = K_OUTH;
                    end else begin
                        p.kind = (s.greater_run == 2'd1) ? K_OUT : K_APP;
                    end
                    p.done = 1'b0;
                end else if (s.amp_run != '0) begin
                    p.st.amp_run = '0;
                    p.emit = 1'b1;
                    p.kind = (s.amp_run == 2'd1) ? K_AMP : K_AMP2;
                    p.done = 1'b0;
                end else if (s.pipe_run != '0) begin
                    p.st.pipe_run = '0;
                    p.emit = 1'b1;
                    p.kind = (s.pipe_run == 2'd1) ? K_PIPE : K_PIPE2;
                    p.done = 1'b0;
                end else if (!p.st.quoting && c.is_ws) begin
                    p.st.escape_pending = 1'b0;
                    if (s.word_open) begin
                        p.st.word_open = 1'b0;
                        p.emit = 1'b1;
                        p.kind = K_WEND;
                        p.done = 1'b0;
                    end
                end else if (!p.st.quoting && !s.escape_pending && c.is_caret) begin
                    p.st.escape_pending = 1'b1;
                end else begin
                    p.st.word_open      = 1'b1;
                    p.st.escape_pending = 1'b0;
                    p.emit  = 1'b1;
                    p.wchar = ch;
                end
            end
        end
        return p;
    endfunction

    t_tok_state r_st, n_st;
    logic       r_out_valid, n_out_valid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_wchar, n_wchar;
    logic       r_last, n_last;
    t_pass      w_p1;
    t_pass      w_p2;
    logic       w_adv;
    logic       w_emit;

    // the second pass looks ahead so that the last token of a run is known
    assign w_p1  = f_pass(r_st, i_head.entry.cls, i_head.entry.ch);
    assign w_p2  = f_pass(w_p1.st, i_head.entry.cls, i_head.entry.ch);
    assign w_adv = i_head.valid && (!r_out_valid || i_ready);

    // pass sequencing and pop decision
    always_comb begin
        n_st    = r_st;
        n_kind  = r_kind;
        n_wchar = r_wchar;
        n_last  = r_last;
        w_emit  = 1'b0;
        o_pop   = 1'b0;
        if (w_adv) begin
            if (i_head.entry.eoi) begin
                // flush: word end, pending close, then end
                w_emit  = 1'b1;
                n_wchar = '0;
                n_last  = 1'b0;
                if (r_st.word_open) begin
                    n_st.word_open = 1'b0;
                    n_kind = K_WEND;
                end else if (r_st.close_paren_seen) begin
                    n_st.close_paren_seen = 1'b0;
                    n_kind = K_CLOSE;
                end else begin
                    n_st   = '0;
                    n_kind = K_END;
                    n_last = 1'b1;
                    o_pop  = 1'b1;
                end
            end else begin
                w_emit  = w_p1.emit;
                n_kind  = w_p1.kind;
                n_wchar = w_p1.wchar;
                if (w_p1.done) begin
                    n_st   = w_p1.st;
                    n_last = 1'b1;
                    o_pop  = 1'b1;
                end else if (!w_p2.emit) begin
                    n_st   = w_p2.st;
                    n_last = 1'b1;
                    o_pop  = 1'b1;
                end else begin
                    n_st   = w_p1.st;
                    n_last = 1'b0;
                end
            end
        end
    end

    // output register, held while the sink stalls
    always_comb begin
        if (w_adv && w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_kind  <= n_kind;
            r_wchar <= n_wchar;
            r_last  <= n_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_word_char = r_wchar;
    assign o_last      = r_last;

endmodule

`default_nettype wire

FILE: rtl/command_line_tokenizer.sv
// command line tokenizer top level: front end queue feeding the token back end
// depends on clt_pkg, clt_front, clt_back
//
// channel   dir  tdata             tuser                tlast
// s         in   [7:0] ch          [0] end_of_input     -
// m         out  [7:0] word_char   [3:0] kind           last_of_run
//
// the back end emits the tokens of a queued character one after another and pops
// it with the last of them, or with none; an end item is popped with its end token
// the front end takes a character every cycle while the queue has room
// the queue of QUEUE_DEPTH entries absorbs bursts of operator tokens
// reset is synchronous, active low, and clears all tokenizer state
// a stalled output holds its token while the queue keeps filling
`default_nettype none

module command_line_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] ch
    input  wire logic       i_s_tuser,   // [0] end_of_input
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] word_char
    output logic [3:0]      o_m_tuser,   // [3:0] kind
    output logic            o_m_tlast
);
    import clt_pkg::*;

    t_queue_head w_head;
    logic        w_pop;

    clt_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_ch    (i_s_tdata),
        .i_eoi   (i_s_tuser),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    clt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_kind      (o_m_tuser),
        .o_word_char (o_m_tdata),
        .o_last      (o_m_tlast)
    );

`ifndef ASSERT_OFF
    // end token always closes its run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == K_END |-> o_m_tlast)
        else $error("end token without tlast");

    // only word characters carry a character value
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != K_WCHAR |-> o_m_tdata == 8'd0)
        else $error("nonzero data on a non-character token");

    // backpressure on the input only when the queue holds work
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> w_head.valid)
        else $error("input stalled with an empty queue");

    // a pop only happens on a valid head
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue pop without an entry");
`endif

endmodule

`default_nettype wire
